### rtl/gsup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsup_pkg
// Shared types, codes and constants of the gas sensor serial poll core.
// ----------------------------------------------------------------------------
package gsup_pkg;

  localparam logic [1:0] MODE_POLL = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_BYTE = 2'd2;

  localparam logic [2:0] FRAME_LEN = 3'd5;
  localparam logic [2:0] LAST_IDX  = 3'd4;

  localparam logic [7:0] HDR_BYTE0 = 8'hFF;
  localparam logic [7:0] HDR_BYTE1 = 8'hFA;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    KIND_REQ       = 2'd0,
    KIND_READING   = 2'd1,
    KIND_FRAME_ERR = 2'd2,
    KIND_TIMEOUT   = 2'd3
  } kind_t;

  typedef struct packed {
    logic        burst;
    kind_t       kind;
    logic [15:0] ppm;
  } res_t;

  function automatic logic [7:0] request_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hFF;
      3'd1:    b = 8'hFE;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h02;
      3'd4:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/gsup_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsup_ctrl
// Poll state, receive buffer, elapsed timer and the per-item decision logic.
// ----------------------------------------------------------------------------
module gsup_ctrl import gsup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        res_fire,
  output res_t        res
);

  logic        waiting;
  logic        waiting_next;
  logic [2:0]  rx_count;
  logic [2:0]  rx_count_next;
  logic [15:0] elapsed_ms;
  logic [15:0] elapsed_ms_next;
  logic [15:0] timeout_ms;
  logic        byte_we;
  logic [7:0]  hdr0;
  logic [7:0]  hdr1;
  logic [7:0]  ppm_hi;
  logic [7:0]  ppm_lo;

  always_comb begin
    waiting_next    = waiting;
    rx_count_next   = rx_count;
    elapsed_ms_next = elapsed_ms;
    byte_we         = 1'b0;
    res_fire        = 1'b0;
    res.burst       = 1'b0;
    res.kind        = KIND_REQ;
    res.ppm         = '0;
    if (accept) begin
      case (mode)
        MODE_POLL: begin
          if (!waiting) begin
            rx_count_next   = '0;
            elapsed_ms_next = '0;
            waiting_next    = 1'b1;
            res_fire        = 1'b1;
            res.burst       = 1'b1;
          end else if (rx_count == FRAME_LEN) begin
            res_fire      = 1'b1;
            waiting_next  = 1'b0;
            rx_count_next = '0;
            if (hdr0 == HDR_BYTE0 && hdr1 == HDR_BYTE1) begin
              res.kind = KIND_READING;
              res.ppm  = {ppm_hi, ppm_lo};
            end else begin
              res.kind = KIND_FRAME_ERR;
            end
          end else if (elapsed_ms > timeout_ms) begin
            res_fire      = 1'b1;
            res.kind      = KIND_TIMEOUT;
            waiting_next  = 1'b0;
            rx_count_next = '0;
          end
        end
        MODE_TICK: begin
          if (elapsed_ms != '1) begin
            elapsed_ms_next = elapsed_ms + 16'd1;
          end
        end
        MODE_BYTE: begin
          if (waiting && rx_count < FRAME_LEN) begin
            byte_we       = 1'b1;
            rx_count_next = rx_count + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting    <= 1'b0;
      rx_count   <= '0;
      elapsed_ms <= '0;
      timeout_ms <= TIMEOUT_RESET;
    end else begin
      waiting    <= waiting_next;
      rx_count   <= rx_count_next;
      elapsed_ms <= elapsed_ms_next;
      if (cfg_we) begin
        timeout_ms <= cfg_wdata;
      end
    end
  end

  // byte 2 of the response carries nothing that is reported
  always_ff @(posedge clk) begin
    if (byte_we) begin
      case (rx_count)
        3'd0:    hdr0   <= rx_byte;
        3'd1:    hdr1   <= rx_byte;
        3'd3:    ppm_hi <= rx_byte;
        3'd4:    ppm_lo <= rx_byte;
        default: begin
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rx_count <= FRAME_LEN)
    else $error("receive count beyond frame length");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !waiting |-> rx_count == 3'd0)
    else $error("receive bytes held while idle");

endmodule

### rtl/gsup_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsup_out
// Result register; plays out the five request bytes of a poll one per item.
// ----------------------------------------------------------------------------
module gsup_out import gsup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_fire,
  input  res_t        res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  tx_byte,
  output logic [15:0] gas_ppm,
  output logic        last
);

  res_t       held;
  logic [2:0] idx;
  logic       take;
  logic       final_item;

  assign take       = out_valid && out_ready;
  assign final_item = !held.burst || idx == LAST_IDX;
  assign free       = !out_valid || (take && final_item);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (final_item) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      held <= res;
    end
  end

  assign result_kind = held.kind;
  assign gas_ppm     = held.ppm;
  assign tx_byte     = held.burst ? request_byte(idx) : 8'h00;
  assign last        = final_item;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && held.burst |-> idx <= LAST_IDX)
    else $error("request byte index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> free)
    else $error("result loaded over a pending item");

  a_single_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && !held.burst |-> held.kind != KIND_REQ)
    else $error("single result carries request kind");

endmodule

### rtl/gas_sensor_uart_poll_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_uart_poll_core
// Request and response poll of a serial gas sensor.
// ----------------------------------------------------------------------------
// An input item is taken in one cycle and its result is registered in the
// next; ticks, received bytes and waiting polls flow at one item per clock
// while the output stage is free. A poll from idle yields the five
// request bytes FF FE 02 02 03, one per output item, and holds in_ready low
// until the fifth is being taken. The output register lets a new item be
// accepted in the same cycle that the last pending result is taken.
// timeout_ms may be written at any time the core is idle; it resets to 1000.
module gas_sensor_uart_poll_core import gsup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  tx_byte,
  output logic [15:0] gas_ppm,
  output logic        last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic accept;
  logic free;
  logic res_fire;
  res_t res;

  assign in_ready = free;
  assign accept   = in_valid && in_ready;

  gsup_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_fire  (res_fire),
    .res       (res)
  );

  gsup_out u_out (
    .clk         (clk),
    .rst         (rst),
    .res_fire    (res_fire),
    .res         (res),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .gas_ppm     (gas_ppm),
    .last        (last)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gas sensor serial poll core.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a bursty valid/ready driver. Every accepted
// item updates a behavioral copy of the poll state machine, and that copy
// queues the replies it expects. A monitor stalls the output on a changing
// pattern and checks each reply field by field against the oldest entry.
// The run covers a directed part, random request/response exchanges under
// several timeouts, and short waits at the two largest timeout values.
// ----------------------------------------------------------------------------
module tb_top;
  import gsup_pkg::*;

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [39:0] REQ_FRAME    = 40'hFFFE020203;
  localparam int          DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0] md;
    logic [7:0] bt;
  } poll_input_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx;
    logic [15:0] ppm;
    logic        lst;
  } poll_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_POLL;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  tx_byte;
  logic [15:0] gas_ppm;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  poll_input_t pend_q[$];
  poll_reply_t reply_q[$];

  // behavioral copy of the core state
  logic        st_waiting = 1'b0;
  int          st_count = 0;
  logic [7:0]  st_buf [5];
  logic [15:0] st_elapsed = 16'd0;
  logic [15:0] st_timeout = TIMEOUT_RESET;

  int n_errors = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_bursts = 0;
  int n_readings = 0;
  int n_frame_errs = 0;
  int n_timeouts = 0;

  int burst_left = 4;
  int gap_left = 0;
  int ready_phase = 0;
  int ready_style = 0;
  poll_input_t nxt;
  poll_reply_t want;

  gas_sensor_uart_poll_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .gas_ppm     (gas_ppm),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_reply(input kind_t kind, input logic [7:0] tx,
                                     input logic [15:0] ppm, input logic lst);
    poll_reply_t r;
    r.kind = kind;
    r.tx   = tx;
    r.ppm  = ppm;
    r.lst  = lst;
    reply_q.push_back(r);
  endfunction

  function automatic void predict_poll_step(input logic [1:0] md, input logic [7:0] bt);
    case (md)
      MODE_TICK: begin
        if (st_elapsed != 16'hFFFF) st_elapsed = st_elapsed + 16'd1;
      end
      MODE_BYTE: begin
        if (st_waiting && st_count < FRAME_LEN) begin
          st_buf[st_count] = bt;
          st_count++;
        end
      end
      MODE_POLL: begin
        if (!st_waiting) begin
          st_count   = 0;
          st_elapsed = 16'd0;
          for (int k = 0; k < FRAME_LEN; k++)
            push_reply(KIND_REQ, REQ_FRAME[39 - 8 * k -: 8], 16'd0, k == FRAME_LEN - 1);
          st_waiting = 1'b1;
          n_bursts++;
        end else if (st_count >= FRAME_LEN) begin
          if (st_buf[0] == HDR_BYTE0 && st_buf[1] == HDR_BYTE1) begin
            push_reply(KIND_READING, 8'h00, {st_buf[3], st_buf[4]}, 1'b1);
            n_readings++;
          end else begin
            push_reply(KIND_FRAME_ERR, 8'h00, 16'd0, 1'b1);
            n_frame_errs++;
          end
          st_waiting = 1'b0;
          st_count   = 0;
        end else if (st_elapsed > st_timeout) begin
          push_reply(KIND_TIMEOUT, 8'h00, 16'd0, 1'b1);
          n_timeouts++;
          st_waiting = 1'b0;
          st_count   = 0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, got_v);
      n_errors++;
    end
  endfunction

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_poll_step(mode, rx_byte);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q.pop_front();
          mode     <= nxt.md;
          rx_byte  <= nxt.bt;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks replies and stalls on a pattern that changes from time to time
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual kind %0d tx 0x%0h ppm %0d last %0b",
                   $time, result_kind, tx_byte, gas_ppm, last);
          n_errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("result_kind", 16'(want.kind), 16'(result_kind));
          check_field("tx_byte", 16'(want.tx), 16'(tx_byte));
          check_field("gas_ppm", want.ppm, gas_ppm);
          check_field("last", 16'(want.lst), 16'(last));
        end
      end
      ready_phase++;
      if (ready_phase % 40 == 0) ready_style = $urandom_range(0, 3);
      case (ready_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ready_phase[1];
      endcase
    end
  end

  function automatic void queue_item(input logic [1:0] md, input logic [7:0] bt);
    poll_input_t it;
    it.md = md;
    it.bt = bt;
    pend_q.push_back(it);
    if (md != MODE_UNUSED) n_queued++;
  endfunction

  function automatic void queue_ticks(input int n);
    repeat (n) queue_item(MODE_TICK, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void queue_frame(input logic [39:0] frame);
    for (int i = 0; i < 5; i++) queue_item(MODE_BYTE, frame[39 - 8 * i -: 8]);
  endfunction

  // one request/response exchange with random content, or a little noise
  function automatic void queue_exchange();
    int style;
    int n_bytes;
    int early_at;
    int ext;
    logic [7:0] b;
    logic [7:0] rnd;
    style = $urandom_range(0, 9);
    rnd = 8'($urandom_range(0, 255));
    if (style == 0) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0:       queue_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
          1:       queue_item(MODE_BYTE, 8'($urandom_range(0, 255)));
          default: queue_item(MODE_TICK, 8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    queue_item(MODE_POLL, rnd);
    if (style == 6) n_bytes = $urandom_range(0, 4);
    else if (style == 7) n_bytes = 5 + $urandom_range(1, 3);
    else n_bytes = 5;
    early_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_bytes) : -1;
    ext = $urandom_range(0, 3);
    for (int i = 0; i < n_bytes; i++) begin
      if (i == early_at) queue_item(MODE_POLL, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0) queue_ticks($urandom_range(1, 4));
      b = 8'($urandom_range(0, 255));
      if (i == 0) begin
        b = HDR_BYTE0;
        if (style == 9) b = HDR_BYTE0 ^ (8'd1 << $urandom_range(0, 7));
      end else if (i == 1) begin
        b = HDR_BYTE1;
        if (style == 8) b = HDR_BYTE1 ^ (8'd1 << $urandom_range(0, 7));
      end else if ((i == 3 || i == 4) && ext == 0) begin
        b = 8'h00;
      end else if ((i == 3 || i == 4) && ext == 1) begin
        b = 8'hFF;
      end
      queue_item(MODE_BYTE, b);
    end
    if (early_at == n_bytes) queue_item(MODE_POLL, 8'($urandom_range(0, 255)));
    if (style == 6) queue_ticks($urandom_range(0, 12));
    queue_item(MODE_POLL, 8'($urandom_range(0, 255)));
  endfunction

  task automatic write_timeout(input logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    st_timeout = v;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || reply_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // drain, then close any open exchange so the core ends up idle
  task automatic settle_idle();
    wait_quiet();
    if (st_waiting) begin
      queue_frame({HDR_BYTE0, HDR_BYTE1, 24'($urandom_range(0, 16777215))});
      queue_item(MODE_POLL, 8'h00);
      wait_quiet();
    end
  endtask

  initial begin : stim
    int start;
    logic [15:0] tmo;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_timeout(16'd2);
    // unused mode, byte and tick while idle
    queue_item(MODE_UNUSED, 8'hA5);
    queue_item(MODE_BYTE, 8'hFF);
    queue_item(MODE_TICK, 8'h00);
    // full response plus an extra byte, timed out too: the response wins
    queue_item(MODE_POLL, 8'h00);
    queue_frame(40'hFFFA00FFFF);
    queue_item(MODE_BYTE, 8'h55);
    queue_ticks(3);
    queue_item(MODE_POLL, 8'hFF);
    // bad header
    queue_item(MODE_POLL, 8'h00);
    queue_frame(40'h7FFA340000);
    queue_item(MODE_POLL, 8'h00);
    // timeout boundary: elapsed equal to the limit, then one past it
    queue_item(MODE_POLL, 8'h00);
    queue_ticks(2);
    queue_item(MODE_POLL, 8'h00);
    queue_item(MODE_TICK, 8'hFF);
    queue_item(MODE_POLL, 8'h00);
    settle_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       tmo = 16'd0;
        1:       tmo = 16'($urandom_range(1, 8));
        2:       tmo = TIMEOUT_RESET;
        default: tmo = 16'd3;
      endcase
      write_timeout(tmo);
      start = n_queued;
      while (n_queued - start < 60) queue_exchange();
      settle_idle();
    end

    // largest timeout: the wait ends only on a complete response
    write_timeout(16'hFFFF);
    queue_item(MODE_POLL, 8'h00);
    queue_ticks(20);
    queue_item(MODE_POLL, 8'h00);
    queue_frame(40'hFFFA01ABCD);
    queue_item(MODE_POLL, 8'h00);
    settle_idle();

    // one below the largest: a short wait stays pending
    write_timeout(16'hFFFE);
    queue_item(MODE_POLL, 8'h00);
    queue_ticks(8);
    queue_item(MODE_POLL, 8'h00);
    settle_idle();

    $display("run covered %0d items: %0d request bursts, %0d readings, %0d frame errors, %0d timeouts",
             n_accepted, n_bursts, n_readings, n_frame_errs, n_timeouts);
    $display("timeouts of 0 to 8, 1000 and the two largest values were used under output stalls");
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
rtl/gsup_pkg.sv
rtl/gsup_ctrl.sv
rtl/gsup_out.sv
rtl/gas_sensor_uart_poll_core.sv
tb/tb_top.sv
